[rtl/core/days_between_dates_assert.svh]
// ============================================================================
// Assertion macros for the days_between_dates block
// Clocked on i_clk and disabled while i_rst_n is low.
// ============================================================================
`ifndef DAYS_BETWEEN_DATES_ASSERT_SVH
`define DAYS_BETWEEN_DATES_ASSERT_SVH

// Same-cycle implication.
`define DBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dbd_pkg.sv]
// ============================================================================
// dbd_pkg
// Types, constants and day-number arithmetic shared by the date blocks.
// ============================================================================
`default_nettype none

package dbd_pkg;

    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 12;
    localparam int DAYNUM_W = 21;
    localparam int DIFF_W   = 21;
    localparam int LEAPS_W  = 11;

    localparam int QDEPTH   = 2;
    localparam int QADDR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [8:0]           DAYS_PER_YEAR = 9'd365;
    localparam logic [DIFF_W-1:0]    DIFF_MAX = {1'b0, {(DIFF_W-1){1'b1}}};
    localparam logic [DIFF_W-1:0]    DIFF_MIN = {1'b1, {(DIFF_W-1){1'b0}}};

    // One calendar date as it arrives on the input stream.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
    } t_date;

    // A request: the second date sits in the upper bits.
    typedef struct packed {
        t_date second;
        t_date first;
    } t_date_pair;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        logic [DAYNUM_W-1:0] num_first;
        logic [DAYNUM_W-1:0] num_second;
        logic                first_is_later;
    } t_qentry;

    // Days in the months before the given month; out-of-range months clamp.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [8:0] v;
        case (month)
            4'd0, 4'd1: v = 9'd0;
            4'd2:       v = 9'd31;
            4'd3:       v = 9'd59;
            4'd4:       v = 9'd90;
            4'd5:       v = 9'd120;
            4'd6:       v = 9'd151;
            4'd7:       v = 9'd181;
            4'd8:       v = 9'd212;
            4'd9:       v = 9'd243;
            4'd10:      v = 9'd273;
            4'd11:      v = 9'd304;
            default:    v = 9'd334;
        endcase
        return v;
    endfunction

    // Closed-form day number: 365 per year, one per multiple of four before it,
    // the month offset, the leap day past February, and the day itself.
    function automatic logic [DAYNUM_W-1:0] day_number(input t_date d);
        logic [DAYNUM_W-1:0] years;
        logic [LEAPS_W-1:0]  leaps;
        logic [YEAR_W:0]     y_plus;
        logic                leap_add;
        y_plus   = {1'b0, d.year} + (YEAR_W+1)'(3);
        leaps    = LEAPS_W'(y_plus >> 2);
        years    = DAYNUM_W'(d.year) * DAYNUM_W'(DAYS_PER_YEAR);
        leap_add = (d.month > MONTH_W'(2)) && (d.year[1:0] == 2'b00);
        return years + DAYNUM_W'(leaps) + DAYNUM_W'(days_before_month(d.month))
               + DAYNUM_W'(leap_add) + DAYNUM_W'(d.day);
    endfunction

endpackage

`default_nettype wire

[rtl/core/dbd_front.sv]
// ============================================================================
// dbd_front
// Accepts a date pair, computes both day numbers and the ordering flag.
// ============================================================================
`default_nettype none

module dbd_front import dbd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_date_pair i_pair,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_qentry         o_entry
);

    logic    r_valid;
    t_qentry r_entry;
    t_qentry n_entry;
    logic    w_later;

    // Stage takes a new request when empty or when its content moves on.
    assign o_ready = !r_valid || i_ready;

    // Lexicographic compare of the raw fields: year, then month, then day.
    always_comb begin
        if (i_pair.first.year != i_pair.second.year) begin
            w_later = i_pair.first.year > i_pair.second.year;
        end else if (i_pair.first.month != i_pair.second.month) begin
            w_later = i_pair.first.month > i_pair.second.month;
        end else begin
            w_later = i_pair.first.day > i_pair.second.day;
        end
    end

    always_comb begin
        n_entry.num_first      = day_number(i_pair.first);
        n_entry.num_second     = day_number(i_pair.second);
        n_entry.first_is_later = w_later;
    end

    // Valid flag is control state; the payload only loads on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_entry <= n_entry;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

[rtl/core/dbd_queue.sv]
// ============================================================================
// dbd_queue
// Short first-in first-out queue between the front end and the back end.
// ============================================================================
`default_nettype none

module dbd_queue import dbd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_qentry i_entry,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_qentry      o_entry,
    output logic [QCNT_W-1:0] o_level
);

    t_qentry              r_mem [QDEPTH];
    logic [QADDR_W-1:0]   r_wr_ptr;
    logic [QADDR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;
    logic [QADDR_W-1:0]   n_wr_ptr;
    logic [QADDR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]    n_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointer and fill-count update with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QADDR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QADDR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rd_ptr];
    assign o_level = r_count;

endmodule

`default_nettype wire

[rtl/core/dbd_back.sv]
// ============================================================================
// dbd_back
// Subtracts the day numbers, saturates, and holds the result for the sink.
// ============================================================================
`default_nettype none

module dbd_back import dbd_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_qentry      i_entry,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [DIFF_W-1:0] o_diff,
    output logic              o_later
);

    logic                r_valid;
    logic [DIFF_W-1:0]   r_diff;
    logic                r_later;
    logic [DIFF_W-1:0]   n_diff;
    logic [DAYNUM_W:0]   w_sub;

    assign o_ready = !r_valid || i_ready;

    // One extra bit keeps the sign; clamp when it disagrees with the next bit.
    always_comb begin
        w_sub = {1'b0, i_entry.num_first} - {1'b0, i_entry.num_second};
        if (w_sub[DAYNUM_W] != w_sub[DAYNUM_W-1]) begin
            n_diff = w_sub[DAYNUM_W] ? DIFF_MIN : DIFF_MAX;
        end else begin
            n_diff = w_sub[DIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_diff  <= n_diff;
            r_later <= i_entry.first_is_later;
        end
    end

    assign o_valid = r_valid;
    assign o_diff  = r_diff;
    assign o_later = r_later;

endmodule

`default_nettype wire

[rtl/core/days_between_dates.sv]
// Path: a request accepted at the input is registered in the front stage, written
// into the queue, and then registered in the output register before it is shown.
// Throughput: one request per cycle while m_axis_tready stays high, set by the front
// stage, the queue and the output register, each of which moves one entry per cycle.
// Reset: synchronous, active low; clears all valid flags and queue pointers.
// ============================================================================
// days_between_dates
// Signed day count between two dates, with a flag for the first being later.
// ============================================================================
`default_nettype none

`include "days_between_dates_assert.svh"

module days_between_dates import dbd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // first_month[3:0], first_day[8:4], first_year[20:9], second_month[24:21],
    // second_day[29:25], second_year[41:30], zeros[47:42]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // day_difference[20:0] (signed), first_is_later[21], zeros[23:22]
    output logic [23:0]      m_axis_tdata
);

    t_date_pair          w_pair;
    logic                w_in_accept;
    logic                w_f_valid;
    logic                w_f_ready;
    t_qentry             w_f_entry;
    logic                w_q_valid;
    logic                w_q_ready;
    t_qentry             w_q_entry;
    logic [QCNT_W-1:0]   w_q_level;
    logic [DIFF_W-1:0]   w_diff;
    logic                w_later;

    assign w_pair = s_axis_tdata[$bits(t_date_pair)-1:0];
    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    dbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pair  (w_pair),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_entry (w_f_entry)
    );

    dbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_entry (w_f_entry),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_entry (w_q_entry),
        .o_level (w_q_level)
    );

    dbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_entry (w_q_entry),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_diff  (w_diff),
        .o_later (w_later)
    );

    assign m_axis_tdata = {2'b00, w_later, w_diff};

    // An accepted request is held in the front stage on the next cycle.
    `DBD_ASSERT_NEXT(a_front_loads, w_in_accept, w_f_valid, "front stage missed a request")

    // A front entry blocked by a full queue is not dropped.
    `DBD_ASSERT_NEXT(a_front_holds, w_f_valid && !w_f_ready, w_f_valid, "front entry lost")

    // The queue never holds more entries than its depth.
    `DBD_ASSERT_NOW(a_queue_bound, 1'b1, w_q_level <= QCNT_W'(QDEPTH), "queue overfilled")

endmodule

`default_nettype wire
